### rtl/core/four_level_priority_job_queue_core_macros.svh
// Assertion macros for the job queue core checker.
// They expect clk and arst_n in scope.
`ifndef FOUR_LEVEL_PRIORITY_JOB_QUEUE_CORE_MACROS_SVH
`define FOUR_LEVEL_PRIORITY_JOB_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define PQC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PQC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/pqc_pkg.sv
package pqc_pkg;

	localparam int LEVEL_COUNT      = 4;
	localparam int LEVEL_W          = 2;
	localparam int JOB_W            = 32;
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int HANDLE_WIDTH_DEF = 32;
	localparam int CMDQ_DEPTH       = 2;

	typedef enum logic {
		KIND_PUSH  = 1'b0,
		KIND_FETCH = 1'b1
	} kind_t;

	// classified item handed from front to back
	typedef struct packed {
		kind_t                  kind;
		logic [LEVEL_W-1:0]     level;
		logic [LEVEL_COUNT-1:0] ceiling;  // fetch: levels it may take from
		logic [JOB_W-1:0]       handle;
	} cmd_t;

endpackage

### rtl/core/pqc_ram.sv
module pqc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/pqc_front.sv
module pqc_front import pqc_pkg::*; (
	input  logic               start,
	input  logic               kind,
	input  logic [LEVEL_W-1:0] level,
	input  logic [JOB_W-1:0]   job_handle,
	input  logic               q_full,
	output logic               busy,
	output logic               push,
	output cmd_t               push_cmd
);

	assign busy = q_full;
	assign push = start && !q_full;

	// decode kind; fetch turns its ceiling into a level mask
	always_comb begin
		push_cmd.kind    = kind_t'(kind);
		push_cmd.level   = level;
		push_cmd.handle  = job_handle;
		push_cmd.ceiling = '0;
		unique case (kind_t'(kind))
			KIND_PUSH: begin
				push_cmd.ceiling = '0;
			end
			KIND_FETCH: begin
				push_cmd.handle = '0;
				for (int i = 0; i < LEVEL_COUNT; i++) begin
					push_cmd.ceiling[i] = (LEVEL_W'(i) <= level);
				end
			end
			default: begin
				push_cmd.ceiling = '0;
			end
		endcase
	end

endmodule

### rtl/core/pqc_cmdq.sv
module pqc_cmdq import pqc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic not_empty,
	output logic full
);

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             slot_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(CMDQ_DEPTH));
	assign head      = slot_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/pqc_back.sv
module pqc_back import pqc_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               done,
	output logic               served,
	output logic [JOB_W-1:0]   out_handle,
	output logic [LEVEL_W-1:0] served_level,
	output logic               dropped
);

	localparam int SLOT_W    = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W     = SLOT_W + 1;
	localparam int ADDR_W    = LEVEL_W + SLOT_W;
	localparam int RAM_DEPTH = LEVEL_COUNT * (2 ** SLOT_W);

	logic [SLOT_W-1:0] head_q  [LEVEL_COUNT];
	logic [CNT_W-1:0]  count_q [LEVEL_COUNT];

	logic                    is_push;
	logic [LEVEL_W-1:0]      push_lvl;
	logic                    q_full;
	logic [SUM_W-1:0]        tail_sum;
	logic [SLOT_W-1:0]       tail_slot;
	logic [LEVEL_COUNT-1:0]  avail;
	logic                    hit;
	logic [LEVEL_W-1:0]      pick_lvl;
	logic [SLOT_W-1:0]       pick_head;
	logic [SLOT_W-1:0]       head_next;
	logic                    do_write;
	logic                    do_read;
	logic [ADDR_W-1:0]       waddr;
	logic [ADDR_W-1:0]       raddr;
	logic [HANDLE_WIDTH-1:0] wdata;
	logic [HANDLE_WIDTH-1:0] rdata;

	logic               valid_s2;
	logic               served_s2;
	logic               dropped_s2;
	logic [LEVEL_W-1:0] level_s2;

	// push: tail slot = head + count, wrapped once
	assign is_push   = (cmd.kind == KIND_PUSH);
	assign push_lvl  = cmd.level;
	assign q_full    = (count_q[push_lvl] == CNT_W'(QUEUE_DEPTH));
	assign tail_sum  = SUM_W'(head_q[push_lvl]) + SUM_W'(count_q[push_lvl]);
	assign tail_slot = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
		SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);

	// fetch: highest non-empty level inside the ceiling
	always_comb begin
		pick_lvl = '0;
		for (int i = 0; i < LEVEL_COUNT; i++) begin
			avail[i] = (count_q[i] != '0) && cmd.ceiling[i];
			if (avail[i]) begin
				pick_lvl = LEVEL_W'(i);
			end
		end
	end

	assign hit       = |avail;
	assign pick_head = head_q[pick_lvl];
	assign head_next = (pick_head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : pick_head + 1'b1;

	assign do_write = cmd_valid && is_push && !q_full;
	assign do_read  = cmd_valid && !is_push && hit;
	assign waddr    = {push_lvl, tail_slot};
	assign raddr    = {pick_lvl, pick_head};
	assign wdata    = HANDLE_WIDTH'(cmd.handle);

	pqc_ram #(
		.WIDTH (HANDLE_WIDTH),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_write),
		.waddr (waddr),
		.wdata (wdata),
		.re    (do_read),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVEL_COUNT; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (do_write) begin
				count_q[push_lvl] <= count_q[push_lvl] + 1'b1;
			end
			if (do_read) begin
				head_q[pick_lvl]  <= head_next;
				count_q[pick_lvl] <= count_q[pick_lvl] - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			served_s2  <= 1'b0;
			dropped_s2 <= 1'b0;
			level_s2   <= '0;
		end else begin
			valid_s2   <= cmd_valid;
			served_s2  <= do_read;
			dropped_s2 <= cmd_valid && is_push && q_full;
			level_s2   <= do_read ? pick_lvl : '0;
		end
	end

	assign done         = valid_s2;
	assign served       = served_s2;
	assign dropped      = dropped_s2;
	assign served_level = level_s2;
	assign out_handle   = served_s2 ? JOB_W'(rdata) : '0;

endmodule

### rtl/core/four_level_priority_job_queue_core.sv
// Channel   Handshake        Fields
// -------   --------------   ---------------------------------------------
// item in   start / busy     kind, level, job_handle
// result    done (strobe)    served, out_handle, served_level, dropped
//
// One item per cycle sustained while busy is low; each result shows
// on done once the item has passed the command queue and the back
// end's result register. The rate rests on the back end's single pass
// over the per-level counters and one job store write or read per item.
// Reset clears the heads, counts and the command queue; the job store is
// not cleared and needs no clearing pass, since only held slots are read.
// done lasts one cycle and cannot be held off; busy rises only when the
// command queue between front and back is full.
module four_level_priority_job_queue_core import pqc_pkg::*; #(
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
	parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [LEVEL_W-1:0] level,
	input  logic [JOB_W-1:0]   job_handle,
	output logic               done,
	output logic               served,
	output logic [JOB_W-1:0]   out_handle,
	output logic [LEVEL_W-1:0] served_level,
	output logic               dropped
);

	// front -> command queue
	logic q_push;
	cmd_t q_push_cmd;
	logic q_full;

	// command queue -> back; back never stalls, so it drains every cycle
	cmd_t q_head;
	logic q_not_empty;

	pqc_front u_front (
		.start      (start),
		.kind       (kind),
		.level      (level),
		.job_handle (job_handle),
		.q_full     (q_full),
		.busy       (busy),
		.push       (q_push),
		.push_cmd   (q_push_cmd)
	);

	pqc_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.pop       (q_not_empty),
		.head      (q_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	// back: per-level head/count, store access, result register
	pqc_back #(
		.QUEUE_DEPTH  (QUEUE_DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (q_head),
		.done         (done),
		.served       (served),
		.out_handle   (out_handle),
		.served_level (served_level),
		.dropped      (dropped)
	);

endmodule

### rtl/core/pqc_checker.sv
`include "four_level_priority_job_queue_core_macros.svh"

module pqc_checker import pqc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               kind,
	input logic               done,
	input logic               served,
	input logic [JOB_W-1:0]   out_handle,
	input logic [LEVEL_W-1:0] served_level,
	input logic               dropped
);

	logic push_taken;
	logic res_zero;

	assign push_taken = start && !busy && (kind == KIND_PUSH);
	assign res_zero   = (out_handle == '0) && (served_level == '0);

	// every taken item gets its result after the command queue and the result register
	`PQC_ASSERT_NOW(a_result_latency, start && !busy, ##2 done, "item without result")

	// a push never serves a job
	`PQC_ASSERT_NEXT(a_push_not_served, push_taken, ##1 !served, "push served a job")

	`PQC_ASSERT_NOW(a_served_dropped_excl, done, !(served && dropped), "served and dropped together")

	// nothing served: handle and level read zero
	`PQC_ASSERT_NOW(a_empty_zero, done && !served, res_zero, "unserved result not zero")

endmodule

bind four_level_priority_job_queue_core pqc_checker u_pqc_checker (.*);

### sim/four_level_priority_job_queue_core_tb.sv
`timescale 1ns / 100ps

module four_level_priority_job_queue_core_tb;
	import pqc_pkg::*;

	localparam int DEPTH      = QUEUE_DEPTH_DEF;
	localparam int WDOG_LIMIT = 2000;   // cycles with no item taken and no result
	localparam int DRAIN_WAIT = 16;     // wait after the last item for its result; generous margin
	localparam int MAX_SHOWN  = 10;

	localparam logic [LEVEL_W-1:0] LVL_LOW    = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_NORMAL = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_HIGH   = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_CRIT   = 2'd3;

	// one item as the sender presents it
	typedef struct packed {
		kind_t              op;
		logic [LEVEL_W-1:0] lvl;
		logic [JOB_W-1:0]   handle;
	} job_cmd_t;

	// one result as the block should report it
	typedef struct packed {
		logic               served;
		logic [JOB_W-1:0]   handle;
		logic [LEVEL_W-1:0] lvl;
		logic               dropped;
	} job_outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               kind = 1'b0;
	logic [LEVEL_W-1:0] level = '0;
	logic [JOB_W-1:0]   job_handle = '0;
	logic               busy;
	logic               done;
	logic               served;
	logic [JOB_W-1:0]   out_handle;
	logic [LEVEL_W-1:0] served_level;
	logic               dropped;

	four_level_priority_job_queue_core dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// items waiting to be driven, and results waiting to be seen
	job_cmd_t     job_cmds[$];
	job_outcome_t job_outcomes[$];

	// mirror of the four level FIFOs
	logic [JOB_W-1:0] mirror_store [LEVEL_COUNT][DEPTH];
	logic [3:0]       mirror_head  [LEVEL_COUNT];
	logic [4:0]       mirror_count [LEVEL_COUNT];

	int n_push, n_drop, n_fetch, n_served, n_empty, peak_fill;
	int n_errors, n_results;

	initial begin
		for (int l = 0; l < LEVEL_COUNT; l++) begin
			mirror_head[l]  = '0;
			mirror_count[l] = '0;
		end
	end

	// Push appends to its level unless that level is full; fetch pops the head of
	// the highest occupied level at or below the ceiling. Only held slots are read.
	function automatic job_outcome_t apply_job(job_cmd_t c);
		job_outcome_t r;
		logic [4:0]   slot;
		logic [3:0]   h;
		r = '0;
		if (c.op == KIND_PUSH) begin
			n_push++;
			if (mirror_count[c.lvl] >= DEPTH) begin
				r.dropped = 1'b1;
				n_drop++;
			end else begin
				slot = {1'b0, mirror_head[c.lvl]} + mirror_count[c.lvl];
				if (slot >= DEPTH)
					slot = slot - DEPTH;
				mirror_store[c.lvl][slot[3:0]] = c.handle;
				mirror_count[c.lvl] = mirror_count[c.lvl] + 1;
				if (mirror_count[c.lvl] > peak_fill)
					peak_fill = mirror_count[c.lvl];
			end
		end else begin
			n_fetch++;
			for (int q = int'(c.lvl); q >= 0; q--) begin
				if (!r.served && mirror_count[q] != 0) begin
					h = mirror_head[q];
					r.served = 1'b1;
					r.handle = mirror_store[q][h];
					r.lvl    = LEVEL_W'(q);
					mirror_head[q]  = (h == DEPTH - 1) ? '0 : h + 1'b1;
					mirror_count[q] = mirror_count[q] - 1;
				end
			end
			if (r.served)
				n_served++;
			else
				n_empty++;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- driver
	// Bursts of back-to-back items separated by random gaps. A gap may be zero,
	// so long stretches without idling also occur. An item stays on the pins
	// until the edge where busy is low.
	job_cmd_t cur_cmd;
	int       burst_left = 0;
	int       gap_left = 0;
	int       n_taken = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				job_outcomes.insert(job_outcomes.size(), apply_job(cur_cmd));
				n_taken++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (job_cmds.size() != 0) begin
					cur_cmd = job_cmds.pop_front();
					start      <= 1'b1;
					kind       <= cur_cmd.op;
					level      <= cur_cmd.lvl;
					job_handle <= cur_cmd.handle;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------- monitor
	task automatic flag_mismatch(string what, logic [JOB_W-1:0] exp_v,
			logic [JOB_W-1:0] act_v);
		n_errors++;
		if (n_errors <= MAX_SHOWN)
			$display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
				$realtime, n_results, what, exp_v, act_v);
	endtask

	always @(posedge clk) begin
		job_outcome_t want;
		if (arst_n && done) begin
			if (job_outcomes.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_SHOWN)
					$display("[%0t] result with no item outstanding", $realtime);
			end else begin
				want = job_outcomes.pop_front();
				if (served !== want.served)
					flag_mismatch("served", JOB_W'(want.served), JOB_W'(served));
				if (out_handle !== want.handle)
					flag_mismatch("out_handle", want.handle, out_handle);
				if (served_level !== want.lvl)
					flag_mismatch("served_level", JOB_W'(want.lvl), JOB_W'(served_level));
				if (dropped !== want.dropped)
					flag_mismatch("dropped", JOB_W'(want.dropped), JOB_W'(dropped));
			end
			n_results++;
		end
	end

	// -------------------------------------------------------------- watchdog
	int stuck_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stuck_cycles <= 0;
			else if (stuck_cycles + 1 >= WDOG_LIMIT) begin
				$display("timeout: no progress for %0d cycles", WDOG_LIMIT);
				$display("== FAIL ==");
				$finish;
			end else
				stuck_cycles <= stuck_cycles + 1;
		end
	end

	// -------------------------------------------------------------- stimulus
	function automatic logic [JOB_W-1:0] pick_handle();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_job(kind_t op, logic [LEVEL_W-1:0] lvl, logic [JOB_W-1:0] h);
		job_cmd_t c;
		c.op     = op;
		c.lvl    = lvl;
		c.handle = h;
		job_cmds.insert(job_cmds.size(), c);
	endtask

	// Segments with a push bias: floods push levels to full and into drops,
	// drains pull them past empty. Half the items of a segment hit one level
	// so that a single FIFO fills and wraps instead of spreading thin.
	task automatic add_random_jobs(int total);
		int   made, seg_len, push_pct;
		logic [LEVEL_W-1:0] focus, lvl;
		made = 0;
		while (made < total) begin
			seg_len = $urandom_range(8, 48);
			case ($urandom_range(0, 3))
				0:       push_pct = 85;
				1:       push_pct = 20;
				default: push_pct = 50;
			endcase
			focus = LEVEL_W'($urandom_range(0, 3));
			for (int i = 0; i < seg_len && made < total; i++) begin
				lvl = $urandom_range(0, 1) ? focus : LEVEL_W'($urandom_range(0, 3));
				add_job(($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_FETCH,
					lvl, pick_handle());
				made++;
			end
		end
	endtask

	initial begin
		// fetches from an empty queue, at the top and bottom ceilings
		add_job(KIND_FETCH, LVL_CRIT, '1);
		add_job(KIND_FETCH, LVL_LOW, '0);
		// extreme handles at the extreme levels
		add_job(KIND_PUSH, LVL_LOW, '0);
		add_job(KIND_PUSH, LVL_CRIT, '1);
		// ceiling below critical must take the low entry
		add_job(KIND_FETCH, LVL_HIGH, '0);
		// only critical is held, ceiling excludes it: nothing served
		add_job(KIND_FETCH, LVL_NORMAL, '0);
		add_job(KIND_FETCH, LVL_CRIT, '0);
		// fill one level completely, then one more push is dropped
		for (int i = 0; i <= DEPTH; i++)
			add_job(KIND_PUSH, LVL_HIGH, pick_handle());
		add_job(KIND_PUSH, LVL_NORMAL, 32'h5A5A_A5A5);

		add_random_jobs(650);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// sampled off the rising edge so the driver's updates have settled
		do @(negedge clk);
		while (job_cmds.size() != 0 || start || job_outcomes.size() != 0);
		repeat (DRAIN_WAIT) @(negedge clk);

		if (job_outcomes.size() != 0) begin
			n_errors += job_outcomes.size();
			$display("%0d results never arrived", job_outcomes.size());
		end

		$display("Covered %0d pushes (%0d dropped on a full level), %0d fetches",
			n_push, n_drop, n_fetch);
		$display("  %0d fetches served, %0d found nothing eligible; deepest level %0d/%0d",
			n_served, n_empty, peak_fill, DEPTH);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
